// ----- src/run_merge_sorter_assert.svh -----
// ----------------------------------------------------------------------------
// run_merge_sorter_assert.svh
// Assertion macros shared by the run merge sorter RTL.
// ----------------------------------------------------------------------------
`ifndef RUN_MERGE_SORTER_ASSERT_SVH
`define RUN_MERGE_SORTER_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset
`define RMS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset
`define RMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/rms_pkg.sv -----
// ----------------------------------------------------------------------------
// rms_pkg
// Shared types, defaults and helpers for the run merge sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package rms_pkg;

    // Element width and parameter defaults
    localparam int DATA_W       = 32;
    localparam int CAPACITY_DEF = 64;
    localparam int RUN_LEN_DEF  = 16;

    // Input transfer payload
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     is_final;
    } t_in_item;

    // Output transfer payload
    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     end_of_set;
        logic                     overflowed;
    } t_out_item;

    // Sequencer states
    typedef enum logic [7:0] {
        S_LOAD      = 8'b0000_0001,
        S_INS_RD    = 8'b0000_0010,
        S_INS_CMP   = 8'b0000_0100,
        S_MRG_PASS  = 8'b0000_1000,
        S_MRG_SEG   = 8'b0001_0000,
        S_MRG_RUN   = 8'b0010_0000,
        S_EMIT_RD   = 8'b0100_0000,
        S_EMIT_SHOW = 8'b1000_0000
    } t_state;

    // Signed greater-than on raw element words
    function automatic logic gt(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b);
        gt = ($signed(a) > $signed(b));
    endfunction

endpackage

`default_nettype wire

// ----- src/run_merge_sorter.sv -----
// ----------------------------------------------------------------------------
// run_merge_sorter
// Collects signed elements until a final one, sorts them ascending
// (insertion sort per run, then bottom-up merge passes) and emits them.
// ----------------------------------------------------------------------------
//  Channel   Signals                              Dir  Payload
//  input     i_in_valid / o_in_ready / i_in_data   in   t_in_item
//  output    o_out_valid / i_out_ready / o_out_data out t_out_item
//
//  Loading takes one element per cycle into the element store.
//  Insertion: run starts are skipped; each other element is held while larger ones shift up.
//  Merge pass: each segment is set up, then its halves merge into the other memory (one write port).
//  Emission: each element is read, loaded into the output register and held until transferred.
//  Input stays closed from the final element until the last output transfer.
//  Reset is synchronous and clears control state only.
// ----------------------------------------------------------------------------
`default_nettype none
`include "run_merge_sorter_assert.svh"

module run_merge_sorter #(
    parameter int CAPACITY = rms_pkg::CAPACITY_DEF,
    parameter int RUN_LEN  = rms_pkg::RUN_LEN_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  rms_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output rms_pkg::t_out_item  o_out_data
);

    localparam int DW     = rms_pkg::DATA_W;
    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int MAXV   = (CAPACITY > RUN_LEN) ? CAPACITY : RUN_LEN;
    localparam int IDX_W  = $clog2(8 * MAXV);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    // Control registers
    rms_pkg::t_state    r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_ovf, n_ovf;
    logic               r_src, n_src;
    logic               r_out_valid, n_out_valid;
    logic               r_first, n_first;
    logic [IDX_W-1:0]   r_i, n_i;
    logic [IDX_W-1:0]   r_lo, n_lo;
    logic [IDX_W-1:0]   r_j, n_j;
    logic [IDX_W-1:0]   r_w, n_w;
    logic [IDX_W-1:0]   r_s, n_s;
    logic [IDX_W-1:0]   r_a, n_a;
    logic [IDX_W-1:0]   r_a_end, n_a_end;
    logic [IDX_W-1:0]   r_b, n_b;
    logic [IDX_W-1:0]   r_b_end, n_b_end;
    logic [IDX_W-1:0]   r_k, n_k;

    // Payload registers
    logic [DW-1:0]      r_held, n_held;
    rms_pkg::t_out_item r_out, n_out;

    // Memories and their registered read data
    logic [DW-1:0]      r_store   [CAPACITY];
    logic [DW-1:0]      r_scratch [CAPACITY];
    logic [DW-1:0]      r_store_qa, r_store_qb;
    logic [DW-1:0]      r_scratch_qa, r_scratch_qb;

    logic               wr_en_store, wr_en_scratch;
    logic [ADDR_W-1:0]  wr_addr;
    logic [DW-1:0]      wr_data;
    logic [IDX_W-1:0]   rd_idx_a, rd_idx_b;
    logic [ADDR_W-1:0]  rd_addr_a, rd_addr_b;

    logic [DW-1:0]      rd_a, rd_b;
    logic [IDX_W-1:0]   n_ext, last_idx;
    logic [IDX_W-1:0]   seg_mid, seg_hi;
    logic               in_xfer, out_xfer;
    logic               take_a, a_ok, b_ok;
    logic               final_xfer, last_xfer, idle_empty, merging;

    assign n_ext     = IDX_W'(r_count);
    assign last_idx  = n_ext - IDX_W'(1);
    assign in_xfer   = i_in_valid && o_in_ready;
    assign out_xfer  = r_out_valid && i_out_ready;
    assign rd_addr_a = rd_idx_a[ADDR_W-1:0];
    assign rd_addr_b = rd_idx_b[ADDR_W-1:0];

    // Select the memory that holds the current data
    assign rd_a = r_src ? r_scratch_qa : r_store_qa;
    assign rd_b = r_src ? r_scratch_qb : r_store_qb;

    // Segment bounds for the merge pass
    assign seg_mid = r_s + r_w - IDX_W'(1);
    assign seg_hi  = r_s + (r_w << 1) - IDX_W'(1);

    // Merge selection: left wins ties to keep arrival order
    assign a_ok   = (r_a <= r_a_end);
    assign b_ok   = (r_b <= r_b_end);
    assign take_a = a_ok && (!b_ok || !rms_pkg::gt(rd_a, rd_b));

    // Sequencer next-state logic
    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_ovf         = r_ovf;
        n_src         = r_src;
        n_out_valid   = r_out_valid;
        n_first       = r_first;
        n_i           = r_i;
        n_lo          = r_lo;
        n_j           = r_j;
        n_w           = r_w;
        n_s           = r_s;
        n_a           = r_a;
        n_a_end       = r_a_end;
        n_b           = r_b;
        n_b_end       = r_b_end;
        n_k           = r_k;
        n_held        = r_held;
        n_out         = r_out;
        wr_en_store   = 1'b0;
        wr_en_scratch = 1'b0;
        wr_addr       = '0;
        wr_data       = '0;
        rd_idx_a      = '0;
        rd_idx_b      = '0;

        case (r_state)
            rms_pkg::S_LOAD: begin
                // Store the element, or drop it and flag overflow when full
                if (in_xfer) begin
                    if (r_count < CNT_W'(CAPACITY)) begin
                        wr_en_store = 1'b1;
                        wr_addr     = r_count[ADDR_W-1:0];
                        wr_data     = i_in_data.value;
                        n_count     = r_count + CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in_data.is_final) begin
                        n_state = rms_pkg::S_INS_RD;
                        n_i     = IDX_W'(1);
                        n_lo    = '0;
                        n_src   = 1'b0;
                    end
                end
            end

            rms_pkg::S_INS_RD: begin
                // Pick the next element to insert, skipping run starts, or start merging when done
                if (r_i >= n_ext) begin
                    n_state = rms_pkg::S_MRG_PASS;
                    n_w     = IDX_W'(RUN_LEN);
                end else if (r_i == r_lo + IDX_W'(RUN_LEN)) begin
                    n_lo = r_i;
                    n_i  = r_i + IDX_W'(1);
                end else begin
                    rd_idx_a = r_i;
                    rd_idx_b = r_i - IDX_W'(1);
                    n_j      = r_i;
                    n_first  = 1'b1;
                    n_state  = rms_pkg::S_INS_CMP;
                end
            end

            rms_pkg::S_INS_CMP: begin
                // Shift larger neighbors up, then drop the held element in place
                n_first = 1'b0;
                n_held  = r_first ? rd_a : r_held;
                wr_en_store = 1'b1;
                wr_addr     = r_j[ADDR_W-1:0];
                if ((r_j > r_lo) && rms_pkg::gt(rd_b, n_held)) begin
                    wr_data  = rd_b;
                    n_j      = r_j - IDX_W'(1);
                    rd_idx_b = r_j - IDX_W'(2);
                end else begin
                    wr_data = n_held;
                    n_i     = r_i + IDX_W'(1);
                    n_state = rms_pkg::S_INS_RD;
                end
            end

            rms_pkg::S_MRG_PASS: begin
                // Start another pass, or emit once one run spans the set
                if (r_w >= n_ext) begin
                    n_state = rms_pkg::S_EMIT_RD;
                    n_k     = '0;
                end else begin
                    n_s     = '0;
                    n_state = rms_pkg::S_MRG_SEG;
                end
            end

            rms_pkg::S_MRG_SEG: begin
                // Set up the two halves of the next segment, or end the pass and swap memories
                if (r_s >= n_ext) begin
                    n_w     = r_w << 1;
                    n_src   = !r_src;
                    n_state = rms_pkg::S_MRG_PASS;
                end else begin
                    n_a      = r_s;
                    n_a_end  = (seg_mid > last_idx) ? last_idx : seg_mid;
                    n_b      = r_s + r_w;
                    n_b_end  = (seg_hi > last_idx) ? last_idx : seg_hi;
                    n_k      = r_s;
                    rd_idx_a = n_a;
                    rd_idx_b = n_b;
                    n_state  = rms_pkg::S_MRG_RUN;
                end
            end

            rms_pkg::S_MRG_RUN: begin
                // Write the smaller head into the other memory and advance
                wr_en_store   = r_src;
                wr_en_scratch = !r_src;
                wr_addr       = r_k[ADDR_W-1:0];
                wr_data       = take_a ? rd_a : rd_b;
                n_k           = r_k + IDX_W'(1);
                if (take_a) begin
                    n_a = r_a + IDX_W'(1);
                end else begin
                    n_b = r_b + IDX_W'(1);
                end
                rd_idx_a = n_a;
                rd_idx_b = n_b;
                if ((n_a > r_a_end) && (n_b > r_b_end)) begin
                    n_s     = r_s + (r_w << 1);
                    n_state = rms_pkg::S_MRG_SEG;
                end
            end

            rms_pkg::S_EMIT_RD: begin
                rd_idx_a = r_k;
                n_state  = rms_pkg::S_EMIT_SHOW;
            end

            rms_pkg::S_EMIT_SHOW: begin
                // Load the output register, then advance on each transfer
                if (!r_out_valid) begin
                    n_out_valid        = 1'b1;
                    n_out.sorted_value = rd_a;
                    n_out.end_of_set   = (r_k + IDX_W'(1) == n_ext);
                    n_out.overflowed   = r_ovf;
                end else if (i_out_ready) begin
                    n_out_valid = 1'b0;
                    if (r_out.end_of_set) begin
                        n_state = rms_pkg::S_LOAD;
                        n_count = '0;
                        n_ovf   = 1'b0;
                    end else begin
                        n_k      = r_k + IDX_W'(1);
                        rd_idx_a = n_k;
                    end
                end
            end

            default: begin
                n_state = rms_pkg::S_LOAD;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rms_pkg::S_LOAD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_src       <= 1'b0;
            r_out_valid <= 1'b0;
            r_first     <= 1'b0;
            r_i         <= '0;
            r_lo        <= '0;
            r_j         <= '0;
            r_w         <= '0;
            r_s         <= '0;
            r_a         <= '0;
            r_a_end     <= '0;
            r_b         <= '0;
            r_b_end     <= '0;
            r_k         <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_src       <= n_src;
            r_out_valid <= n_out_valid;
            r_first     <= n_first;
            r_i         <= n_i;
            r_lo        <= n_lo;
            r_j         <= n_j;
            r_w         <= n_w;
            r_s         <= n_s;
            r_a         <= n_a;
            r_a_end     <= n_a_end;
            r_b         <= n_b;
            r_b_end     <= n_b_end;
            r_k         <= n_k;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_held <= n_held;
        r_out  <= n_out;
    end

    // Element store: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (wr_en_store) begin
            r_store[wr_addr] <= wr_data;
        end
        r_store_qa <= r_store[rd_addr_a];
        r_store_qb <= r_store[rd_addr_b];
    end

    // Merge scratch: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (wr_en_scratch) begin
            r_scratch[wr_addr] <= wr_data;
        end
        r_scratch_qa <= r_scratch[rd_addr_a];
        r_scratch_qb <= r_scratch[rd_addr_b];
    end

    assign o_in_ready  = (r_state == rms_pkg::S_LOAD);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Conditions watched by the checks below
    assign final_xfer = in_xfer && i_in_data.is_final;
    assign last_xfer  = out_xfer && o_out_data.end_of_set;
    assign idle_empty = o_in_ready && (r_count == '0);
    assign merging    = (r_state == rms_pkg::S_MRG_RUN);

    // Loading and emitting never overlap
    `RMS_ASSERT_NOW(a_load_emit_excl, i_clk, i_rst_n, o_in_ready, !o_out_valid, "load during emit")
    // A final input transfer closes the input until the set is emitted
    `RMS_ASSERT_NEXT(a_final_closes, i_clk, i_rst_n, final_xfer, !o_in_ready, "open after final")
    // The last output transfer reopens the input with an empty store
    `RMS_ASSERT_NEXT(a_end_reopens, i_clk, i_rst_n, last_xfer, idle_empty, "input not reopened")
    // Merge writes stay inside the stored set
    `RMS_ASSERT_NOW(a_merge_in_range, i_clk, i_rst_n, merging, r_k < n_ext, "merge past set")
    // The fill count never passes capacity
    `RMS_ASSERT_NOW(a_count_cap, i_clk, i_rst_n, in_xfer, r_count <= CAP_CNT, "count past cap")

endmodule

`default_nettype wire
